// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared word types and constants of the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // value answered by a get that misses
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic                    opcode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] store_value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } out_word_t;

endpackage

// File: hdl/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// flow: a get result is registered in S_DECIDE once the scan pass has read every
//   entry; a new request is taken only in S_IDLE, after the scan and, on a hit
//   or a set insert, the recency pass, so requests do not overlap; both passes
//   share the single ram read port and walk it one entry a cycle
// reset: synchronous, valid flags and entry count cleared at once, capacity
//   back to 16; key, value and rank ram contents are not cleared
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lkvc_pkg::in_word_t       in_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output lkvc_pkg::out_word_t      out_data,
  // capacity register write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  import lkvc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;   // slot index
  localparam int RW = IW;                                     // recency rank
  localparam int CW = $clog2(ENTRIES + 1);                    // entry count
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;              // compare width
  localparam int WW = KEY_W + VAL_W + RW;                     // ram word
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [MW-1:0] CAP_MAX = MW'(ENTRIES);

  // controller states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]         state;
  logic [CAP_W-1:0]   capacity;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      count;

  // latched request
  logic               op;
  logic [KEY_W-1:0]   req_key;
  logic [VAL_W-1:0]   req_val;

  // ram walk: read issue and the compare slot in the cycle after it
  logic               issue;
  logic [IW-1:0]      rd_idx;
  logic               chk_en;
  logic [IW-1:0]      chk_idx;

  // search results gathered over the first pass
  logic               hit_f;
  logic [IW-1:0]      hit_idx;
  logic [VAL_W-1:0]   hit_val;
  logic [RW-1:0]      hit_rank;
  logic               best_f;
  logic [IW-1:0]      best_idx;
  logic [RW-1:0]      best_rank;
  logic               free_f;
  logic [IW-1:0]      free_idx;

  // recency pass control
  logic               ins_mode;  // insert: every other valid entry ages
  logic [IW-1:0]      tgt;       // slot made most recent

  // ram ports
  logic               wr_en;
  logic [WW-1:0]      wr_data;
  logic [WW-1:0]      rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic [RW-1:0]      rd_rank;
  logic               rd_vld;

  // decision terms
  logic [MW-1:0]      cap_eff;
  logic               evict;
  logic [IW-1:0]      slot;
  logic               out_free;
  logic               take;

  assign rd_key  = rd_data[WW-1 -: KEY_W];
  assign rd_val  = rd_data[RW +: VAL_W];
  assign rd_rank = rd_data[RW-1:0];
  assign rd_vld  = valid[chk_idx];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // capacity above the number of slots behaves as a full cache
  assign cap_eff = (MW'(capacity) > CAP_MAX) ? CAP_MAX : MW'(capacity);
  assign evict   = (MW'(count) >= cap_eff);
  // the lowest free slot after the eviction takes the new entry
  assign slot    = (evict && (!free_f || (best_idx < free_idx))) ? best_idx : free_idx;

  // state ram: key, value and rank per slot
  lkvc_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chk_idx),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // write back during the recency pass, one entry behind the read
  always_comb begin
    wr_en   = (state == S_UPDATE) && chk_en && rd_vld;
    wr_data = rd_data;
    if (chk_idx == tgt) begin
      wr_data = {req_key, ((op == OP_SET) ? req_val : rd_val), {RW{1'b0}}};
    end else if (ins_mode || (rd_rank < hit_rank)) begin
      wr_data = {rd_key, rd_val, rd_rank + 1'b1};
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (take) begin
      op      <= in_data.opcode;
      req_key <= in_data.key;
      req_val <= in_data.store_value;
    end
  end

  // the recency pass runs on a get hit once it is answered, or on any set that hits or inserts
  function automatic logic state_to_update(input logic f_op, input logic f_hit,
                                           input logic [CAP_W-1:0] f_cap,
                                           input logic f_free);
    if (f_op == OP_GET) begin
      return f_hit && f_free;
    end
    return f_hit || (f_cap != '0);
  endfunction

  // ram walk counters, shared by both passes
  always_ff @(posedge clk) begin
    if (rst) begin
      issue  <= 1'b0;
      chk_en <= 1'b0;
    end else begin
      chk_en <= issue;
      if (issue) begin
        if (rd_idx == LAST) begin
          issue <= 1'b0;
        end
      end else if (take || (state == S_DECIDE && state_to_update(op, hit_f, capacity,
                                                                 out_free))) begin
        issue <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end else begin
      rd_idx <= '0;
    end
    chk_idx <= rd_idx;
  end

  // first pass: key match, oldest valid entry, lowest free slot
  always_ff @(posedge clk) begin
    if (take) begin
      hit_f  <= 1'b0;
      best_f <= 1'b0;
      free_f <= 1'b0;
    end else if (state == S_SCAN && chk_en) begin
      if (rd_vld && (rd_key == req_key) && !hit_f) begin
        hit_f    <= 1'b1;
        hit_idx  <= chk_idx;
        hit_val  <= rd_val;
        hit_rank <= rd_rank;
      end
      if (rd_vld && (!best_f || (rd_rank > best_rank))) begin
        best_f    <= 1'b1;
        best_idx  <= chk_idx;
        best_rank <= rd_rank;
      end
      if (!rd_vld && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= chk_idx;
      end
    end
  end

  // controller, valid flags and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chk_en && chk_idx == LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op == OP_GET) begin
            // a get waits here until the result register is free
            if (out_free) begin
              state <= hit_f ? S_UPDATE : S_IDLE;
            end
          end else if (hit_f) begin
            state <= S_UPDATE;
          end else if (capacity == '0) begin
            // set miss with no capacity is dropped
            state <= S_IDLE;
          end else begin
            if (evict) begin
              valid[best_idx] <= 1'b0;
            end else begin
              count <= count + 1'b1;
            end
            valid[slot] <= 1'b1;
            state       <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (chk_en && chk_idx == LAST) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // recency pass target and mode, fixed for the whole pass
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      ins_mode <= !hit_f;
      tgt      <= hit_f ? hit_idx : slot;
    end
  end

  // result register parts the output side from the controller
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DECIDE && op == OP_GET && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && op == OP_GET && out_free) begin
      out_data.hit        <= hit_f;
      out_data.read_value <= hit_f ? hit_val : MISS_VALUE;
    end
  end

endmodule
